[hw/rtl/ptt_pkg.sv]
// Shared types, codes and constants of the periodic timer table.
package ptt_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int TAG_BITS = 8;
	localparam int GROUP_BITS = 4;
	localparam logic [63:0] WAKE_NONE = '1;

	typedef enum logic [2:0] {
		K_INSTALL = 3'd0,
		K_PUMP    = 3'd1,
		K_DONE    = 3'd2,
		K_STOPTAG = 3'd3,
		K_STOPGRP = 3'd4,
		K_QUERY   = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]            kind;
		logic [63:0]           now_us;
		logic [62:0]           period;
		logic [TAG_BITS-1:0]   owner_tag;
		logic [GROUP_BITS-1:0] group_id;
		logic [3:0]            entry_index;
		logic                  body_ok;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  slot;
		logic        fired;
		logic [1:0]  status;
		logic        tag_owned;
		logic        any_alive;
		logic [63:0] earliest_wake;
		logic        last;
	} res_t;

	typedef struct packed {
		logic       valid;
		cmd_t       cmd;
		logic       placed;
		logic [3:0] slot;
		logic       owned;
		logic       alive;
		logic [63:0] wake;
	} tok_t;

endpackage

[hw/rtl/periodic_timer_table.sv]
// Top level of the periodic timer table: command injection, cell chain and result register.
//
// A command beat on cmd (valid/ready) carries one operation: install, pump,
// body done, stop by tag, stop by group or query. The command travels as a
// token down a chain of SLOTS cells, one cell per cycle unless the chain
// holds, each cell holding one timer. Each command yields result beats on
// res (valid/ready); the final one has last set. A pump also yields one
// beat for every timer it fires, in slot order, ahead of its summary beat.
// The final result beat is offered once the token has passed every cell of
// the chain and the output register, later if res stalls. A new command
// is taken only when the last one is through: cmd_ready returns in the
// same cycle as the final result enters the output register.
// If the receiver stalls while a beat waits and the token reaches a firing
// cell or the end of the chain, the whole chain holds until the output
// register frees.
// Reset clears every timer to free and empties the chain and the output.
module periodic_timer_table import ptt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	tok_t        tk [SLOTS+1];
	tok_t        tk0_q;
	logic [SLOTS-1:0] fire_v;
	logic [3:0]  fslot [SLOTS];
	logic [3:0]  fire_slot;
	logic        busy_q, out_free, fire_any, adv;
	tok_t        tail;
	res_t        fin;
	res_t        fres;

	assign tk[0]     = tk0_q;
	assign cmd_ready = !busy_q;
	assign out_free  = !res_valid || res_ready;
	assign fire_any  = |fire_v;
	assign tail      = tk[SLOTS];
	assign adv       = out_free || !(fire_any || tail.valid);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		ptt_cell #(.IDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.tok_i(tk[i]), .tok_o(tk[i+1]), .fire(fire_v[i])
		);
		assign fslot[i] = fire_v[i] ? 4'(i) : 4'd0;
	end

	always_comb begin
		fire_slot = '0;
		for (int i = 0; i < SLOTS; i++) begin
			fire_slot = fire_slot | fslot[i];
		end
	end

	always_comb begin
		fres = '0;
		fres.slot = fire_slot;
		fres.fired = 1'b1;
		fres.earliest_wake = WAKE_NONE;
	end

	always_comb begin
		fin = '0;
		fin.earliest_wake = WAKE_NONE;
		fin.last = 1'b1;
		case (tail.cmd.kind)
			K_INSTALL: begin
				if (tail.cmd.period == '0) begin
					fin.status = ST_ZERO;
				end else if (tail.placed) begin
					fin.slot = tail.slot;
				end else begin
					fin.status = ST_FULL;
				end
			end
			K_PUMP: begin
				fin.any_alive     = tail.alive;
				fin.earliest_wake = tail.wake;
			end
			K_DONE:  fin.slot      = tail.cmd.entry_index;
			K_QUERY: fin.tag_owned = tail.owned;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			tk0_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				busy_q <= 1'b1;
				tk0_q  <= '{valid: 1'b1, cmd: cmd, placed: 1'b0, slot: 4'd0,
					owned: 1'b0, alive: 1'b0, wake: WAKE_NONE};
			end else if (adv) begin
				tk0_q.valid <= 1'b0;
			end
			if (adv && fire_any) begin
				res_valid <= 1'b1;
			end else if (adv && tail.valid) begin
				res_valid <= 1'b1;
				busy_q    <= 1'b0;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fire_any) begin
			res <= fres;
		end else if (adv && tail.valid) begin
			res <= fin;
		end
	end

	logic [SLOTS:0] tok_valids;
	always_comb begin
		for (int i = 0; i <= SLOTS; i++) begin
			tok_valids[i] = tk[i].valid;
		end
	end

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valids)) else $error("more than one token in the chain");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> tok_valids == '0) else $error("token present while idle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready) else $error("command taken while busy");
	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && fire_any) |=> (res_valid && res.fired && !res.last))
		else $error("fire result malformed");

endmodule

[hw/rtl/ptt_cell.sv]
// One timer slot of the chain, acting on the command token as it passes.
module ptt_cell import ptt_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  tok_t tok_i,
	output tok_t tok_o,
	output logic fire
);

	logic                  valid_q, busy_q, pend_q;
	logic [62:0]           period_q;
	logic [63:0]           deadline_q;
	logic [TAG_BITS-1:0]   tag_q;
	logic [GROUP_BITS-1:0] group_q;

	logic   hit_idx, tag_eq, do_inst, do_done, valid_n, busy_n, pend_n;
	logic [63:0] dl_n, dl_add, dl_now;
	tok_t   tok_n;
	cmd_t   c;

	assign c       = tok_i.cmd;
	assign hit_idx = 32'(c.entry_index) == 32'(IDX);
	assign tag_eq  = tag_q == c.owner_tag;
	assign dl_add  = deadline_q + {1'b0, period_q};
	assign dl_now  = c.now_us + {1'b0, period_q};

	always_comb begin
		valid_n = valid_q;
		busy_n  = busy_q;
		pend_n  = pend_q;
		dl_n    = deadline_q;
		tok_n   = tok_i;
		fire    = 1'b0;
		do_inst = 1'b0;
		do_done = 1'b0;
		if (tok_i.valid) begin
			case (c.kind)
				K_INSTALL: begin
					if (c.period != '0 && !tok_i.placed && !valid_q) begin
						do_inst      = 1'b1;
						valid_n      = 1'b1;
						busy_n       = 1'b0;
						pend_n       = 1'b0;
						tok_n.placed = 1'b1;
						tok_n.slot   = 4'(IDX);
					end
				end
				K_PUMP: begin
					if (valid_q && !pend_q && !busy_q && deadline_q <= c.now_us) begin
						fire   = 1'b1;
						busy_n = 1'b1;
					end
					if (valid_q && pend_q && !busy_q) begin
						valid_n = 1'b0;
					end
					if (valid_n) begin
						tok_n.alive = 1'b1;
					end
					if (valid_n && !pend_q && !busy_n && deadline_q < tok_i.wake) begin
						tok_n.wake = deadline_q;
					end
				end
				K_DONE: begin
					if (hit_idx && valid_q && busy_q) begin
						busy_n = 1'b0;
						if (c.body_ok) begin
							do_done = 1'b1;
							dl_n = (dl_add <= c.now_us) ? dl_now : dl_add;
						end else begin
							pend_n = 1'b1;
						end
					end
				end
				K_STOPTAG: begin
					if (valid_q && tag_eq) begin
						pend_n = 1'b1;
					end
				end
				K_STOPGRP: begin
					if (valid_q && group_q == c.group_id) begin
						busy_n = 1'b0;
						pend_n = 1'b1;
					end
				end
				K_QUERY: begin
					if (valid_q && !pend_q && tag_eq) begin
						tok_n.owned = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			busy_q  <= 1'b0;
			pend_q  <= 1'b0;
			tok_o   <= '0;
		end else if (adv) begin
			valid_q <= valid_n;
			busy_q  <= busy_n;
			pend_q  <= pend_n;
			tok_o   <= tok_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (do_inst) begin
				period_q   <= c.period;
				deadline_q <= c.now_us + {1'b0, c.period};
				tag_q      <= c.owner_tag;
				group_q    <= c.group_id;
			end else if (do_done) begin
				deadline_q <= dl_n;
			end
		end
	end

endmodule
